// ===== hw/rtl/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// mst_pkg
// shared types, codes and constants of the matrix similarity transform engine
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int MAX_N_DEF     = 8;
    localparam int FRAC_BITS_DEF = 24;

    // fixed field widths
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 3;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int SIZE_W     = 4;
    localparam int MODE_W     = 2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // input op codes
    localparam logic [OP_W-1:0] OP_WR_D = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_R = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN  = 2'd2;

    // mode register codes
    localparam logic [MODE_W-1:0] MODE_PROD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_XFORM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRACE = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd1;

    typedef enum logic [1:0] {
        CMD_WR_D,
        CMD_WR_R,
        CMD_RUN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic [IDX_W-1:0]  last_idx;
        logic [MODE_W-1:0] mode;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_PROD,
        PH_XFORM,
        PH_TRACE
    } phase_t;

endpackage

// ===== hw/rtl/matrix_similarity_transform.sv =====
// ----------------------------------------------------------------------------
// matrix_similarity_transform
// loads D and R entry by entry, then computes R*D, R*D*R^T or trace(D)
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload                       direction
//  item      item_valid/item_stall  op, row, col, value            in
//  res       res_valid/res_stall    out_row, out_col, result, last out
//  cfg       cfg_valid/cfg_ready    cfg_index, cfg_data            in
//
//  entry writes are stored by the back while it is idle; the front takes one
//  transaction a cycle while the four-deep command queue has room
//  each result entry costs n reads of the store ports,
//  then the multiply, round and accumulate stages drain through one
//  shared 32x32 multiplier; a product run is n*n entries, a transform
//  2*n*n entries, a trace one entry of n terms
//  reset clears control state only; the matrix stores are not cleared
//  a stalled result holds the back in its finish step, bar a transform's
//  product entries; the queue takes items until it fills, then item_stall rises
//
module matrix_similarity_transform
    import mst_pkg::*;
#(
    parameter int MAX_N     = MAX_N_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // item channel
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [OP_W-1:0]          op,
    input  logic [IDX_W-1:0]         row,
    input  logic [IDX_W-1:0]         col,
    input  logic signed [DATA_W-1:0] value,
    // result channel
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [IDX_W-1:0]         out_row,
    output logic [IDX_W-1:0]         out_col,
    output logic signed [DATA_W-1:0] result,
    output logic                     last,
    // config write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    logic [SIZE_W-1:0] matrix_size_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [SIZE_W-1:0] n_eff;
    cfg_t              cfg;

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    entry_t            q_entry;
    entry_t            q_head;

    // config registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg <= SIZE_W'(1);
            mode_reg        <= MODE_XFORM;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SIZE: matrix_size_reg <= cfg_data[SIZE_W-1:0];
                CFG_MODE: mode_reg        <= cfg_data[MODE_W-1:0];
                default:  mode_reg        <= mode_reg;
            endcase
        end
    end

    // size zero acts as one, anything above the store size acts as full size
    always_comb
    begin
        if (matrix_size_reg == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (int'(matrix_size_reg) > MAX_N)
        begin
            n_eff = SIZE_W'(MAX_N);
        end
        else
        begin
            n_eff = matrix_size_reg;
        end
    end

    assign cfg.last_idx = IDX_W'(n_eff - SIZE_W'(1));
    assign cfg.mode     = mode_reg;

    // front: decode and filter incoming transactions
    mst_front #(
        .MAX_N (MAX_N)
    ) u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .op         (op),
        .row        (row),
        .col        (col),
        .value      (value),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    // command queue keeps write order ahead of runs
    mst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // back: stores, mac sequencer and result register
    mst_back #(
        .MAX_N     (MAX_N),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .result    (result),
        .last      (last)
    );

endmodule

// ===== hw/rtl/mst_front.sv =====
// ----------------------------------------------------------------------------
// mst_front
// accepts input transactions, decodes the op and drops ignored items
// ----------------------------------------------------------------------------
module mst_front
    import mst_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
)
(
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [OP_W-1:0]          op,
    input  logic [IDX_W-1:0]         row,
    input  logic [IDX_W-1:0]         col,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     q_full,
    output logic                     q_push,
    output entry_t                   q_entry
);

    logic in_range;
    logic keep;

    assign item_stall = q_full;
    assign in_range   = (int'(row) < MAX_N) && (int'(col) < MAX_N);

    always_comb
    begin
        keep          = 1'b0;
        q_entry.kind  = CMD_RUN;
        q_entry.row   = row;
        q_entry.col   = col;
        q_entry.value = value;
        unique case (op)
            OP_WR_D:
            begin
                keep         = in_range;
                q_entry.kind = CMD_WR_D;
            end
            OP_WR_R:
            begin
                keep         = in_range;
                q_entry.kind = CMD_WR_R;
            end
            OP_RUN:
            begin
                keep         = 1'b1;
                q_entry.kind = CMD_RUN;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = item_valid && !q_full && keep;

endmodule

// ===== hw/rtl/mst_queue.sv =====
// ----------------------------------------------------------------------------
// mst_queue
// short command fifo that decouples the front from the back
// ----------------------------------------------------------------------------
module mst_queue
    import mst_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/mst_back.sv =====
// ----------------------------------------------------------------------------
// mst_back
// matrix stores, multiply-accumulate sequencer and result register
// ----------------------------------------------------------------------------
module mst_back
    import mst_pkg::*;
#(
    parameter int MAX_N     = MAX_N_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     q_empty,
    input  entry_t                   q_head,
    output logic                     q_pop,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [IDX_W-1:0]         out_row,
    output logic [IDX_W-1:0]         out_col,
    output logic signed [DATA_W-1:0] result,
    output logic                     last
);

    localparam int CELLS  = MAX_N * MAX_N;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int ACC_W  = TERM_W + IDX_W + 1;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0]  SAT_HI = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  SAT_LO = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_N + int'(c));
    endfunction

    // matrix stores
    logic signed [DATA_W-1:0] d_mem [CELLS];
    logic signed [DATA_W-1:0] r_mem [CELLS];
    logic signed [DATA_W-1:0] p_mem [CELLS];
    logic signed [DATA_W-1:0] d_rdata_reg;
    logic signed [DATA_W-1:0] r_rdata_reg;
    logic signed [DATA_W-1:0] p_rdata_reg;
    logic [ADDR_W-1:0]        d_raddr;
    logic [ADDR_W-1:0]        r_raddr;
    logic [ADDR_W-1:0]        p_raddr;
    logic [ADDR_W-1:0]        q_waddr;
    logic [ADDR_W-1:0]        p_waddr;
    logic                     wr_d;
    logic                     wr_r;
    logic                     wr_p;

    // sequencer
    state_t           state_reg;
    state_t           state_next;
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] i_next;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] j_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic             issuing;
    logic             acc_clr;
    logic             load_res;
    logic             run_go;
    logic             store_p;
    logic             all_done;
    logic             emit_ok;
    logic             res_free;

    // datapath
    logic                     rd_v_reg;
    logic                     rd_last_reg;
    logic                     mul_v_reg;
    logic                     mul_last_reg;
    logic                     term_v_reg;
    logic                     term_last_reg;
    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic signed [PROD_W-1:0] mul_full;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] round_sum;
    logic signed [PROD_W-1:0] round_shift;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [DATA_W-1:0] sat_val;

    // output register
    logic                     res_valid_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic signed [DATA_W-1:0] result_reg;
    logic                     last_reg;

    assign run_go = (cfg.mode == MODE_PROD) || (cfg.mode == MODE_XFORM)
                    || (cfg.mode == MODE_TRACE);

    assign q_waddr = cell_addr(q_head.row, q_head.col);
    assign p_waddr = cell_addr(i_reg, j_reg);
    assign d_raddr = (phase_reg == PH_TRACE) ? cell_addr(k_reg, k_reg) : cell_addr(k_reg, j_reg);
    assign r_raddr = (phase_reg == PH_XFORM) ? cell_addr(j_reg, k_reg) : cell_addr(i_reg, k_reg);
    assign p_raddr = cell_addr(i_reg, k_reg);
    assign wr_d    = q_pop && (q_head.kind == CMD_WR_D);
    assign wr_r    = q_pop && (q_head.kind == CMD_WR_R);

    always_ff @(posedge clk)
    begin
        if (wr_d)
        begin
            d_mem[q_waddr] <= q_head.value;
        end
        if (wr_r)
        begin
            r_mem[q_waddr] <= q_head.value;
        end
        if (wr_p)
        begin
            p_mem[p_waddr] <= sat_val;
        end
        d_rdata_reg <= d_mem[d_raddr];
        r_rdata_reg <= r_mem[r_raddr];
        p_rdata_reg <= p_mem[p_raddr];
    end

    // entry completion
    assign store_p  = (phase_reg == PH_PROD) && (cfg.mode == MODE_XFORM);
    assign all_done = (phase_reg == PH_TRACE) || ((i_reg == cfg.last_idx) && (j_reg == cfg.last_idx));
    assign res_free = !res_valid_reg || !res_stall;
    assign emit_ok  = store_p || res_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && (q_head.kind == CMD_RUN) && run_go)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (k_reg == cfg.last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (term_v_reg && term_last_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (emit_ok)
                begin
                    state_next = (all_done && !store_p) ? ST_IDLE : ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop      = 1'b0;
        issuing    = 1'b0;
        acc_clr    = 1'b0;
        load_res   = 1'b0;
        wr_p       = 1'b0;
        phase_next = phase_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop = !q_empty;
                if (!q_empty && (q_head.kind == CMD_RUN))
                begin
                    i_next  = '0;
                    j_next  = '0;
                    k_next  = '0;
                    acc_clr = 1'b1;
                    unique case (cfg.mode) inside
                        MODE_PROD, MODE_XFORM: phase_next = PH_PROD;
                        MODE_TRACE:            phase_next = PH_TRACE;
                        default:               phase_next = phase_reg;
                    endcase
                end
            end
            ST_ISSUE:
            begin
                issuing = 1'b1;
                k_next  = k_reg + IDX_W'(1);
            end
            ST_DRAIN:
            begin
                issuing = 1'b0;
            end
            ST_FINISH:
            begin
                if (emit_ok)
                begin
                    load_res = !store_p;
                    wr_p     = store_p;
                    acc_clr  = 1'b1;
                    k_next   = '0;
                    if (all_done)
                    begin
                        if (store_p)
                        begin
                            phase_next = PH_XFORM;
                            i_next     = '0;
                            j_next     = '0;
                        end
                    end
                    else if (j_reg == cfg.last_idx)
                    begin
                        i_next = i_reg + IDX_W'(1);
                        j_next = '0;
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // multiply, round, accumulate
    assign op_a     = (phase_reg == PH_XFORM) ? p_rdata_reg : r_rdata_reg;
    assign op_b     = (phase_reg == PH_XFORM) ? r_rdata_reg : d_rdata_reg;
    assign mul_full = op_a * op_b;
    // trace terms are lifted by the fraction so rounding leaves them exact
    assign prod_next = (phase_reg == PH_TRACE) ? (PROD_W'(op_b) <<< FRAC_BITS) : mul_full;
    assign round_sum   = prod_reg + ROUND_HALF;
    assign round_shift = round_sum >>> FRAC_BITS;

    always_comb
    begin
        acc_next = acc_reg;
        if (acc_clr)
        begin
            acc_next = '0;
        end
        else if (term_v_reg)
        begin
            acc_next = acc_reg + ACC_W'(term_reg);
        end
    end

    always_comb
    begin
        if (acc_reg > SAT_HI)
        begin
            sat_val = SAT_HI[DATA_W-1:0];
        end
        else if (acc_reg < SAT_LO)
        begin
            sat_val = SAT_LO[DATA_W-1:0];
        end
        else
        begin
            sat_val = acc_reg[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_PROD;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            rd_v_reg      <= 1'b0;
            rd_last_reg   <= 1'b0;
            mul_v_reg     <= 1'b0;
            mul_last_reg  <= 1'b0;
            term_v_reg    <= 1'b0;
            term_last_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            rd_v_reg      <= issuing;
            rd_last_reg   <= issuing && (k_reg == cfg.last_idx);
            mul_v_reg     <= rd_v_reg;
            mul_last_reg  <= rd_last_reg;
            term_v_reg    <= mul_v_reg;
            term_last_reg <= mul_last_reg;
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        term_reg <= round_shift[TERM_W-1:0];
        acc_reg  <= acc_next;
        if (load_res)
        begin
            out_row_reg <= i_reg;
            out_col_reg <= j_reg;
            result_reg  <= sat_val;
            last_reg    <= all_done;
        end
    end

    assign res_valid = res_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign result    = result_reg;
    assign last      = last_reg;

endmodule

// ===== hw/rtl/mst_checker.sv =====
// ----------------------------------------------------------------------------
// mst_checker
// port-level checks of the matrix similarity transform engine
// ----------------------------------------------------------------------------
module mst_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_stall,
    input logic [2:0]  out_row,
    input logic [2:0]  out_col,
    input logic [31:0] result,
    input logic        last,
    input logic        cfg_ready
);

    // a stalled result transaction keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable({out_row, out_col, result, last}))
        else $error("result changed while stalled");

    // no result while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // the final result of a run always sits on the diagonal
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last |-> out_row == out_col)
        else $error("last result off the diagonal");

    // config writes are never held off
    a_cfg_ready: assert property (@(posedge clk) rst_n |-> cfg_ready)
        else $error("config port not ready");

endmodule

bind matrix_similarity_transform mst_checker u_mst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .result    (result),
    .last      (last),
    .cfg_ready (cfg_ready)
);
